[src/cae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cae_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 20;

  // guard bits added below the coordinates before the passes
  localparam int GUARD_BITS = 16;
  // headroom above the scaled coordinate for abs and cordic growth
  localparam int HEAD_BITS  = 3;

  // angle datapath, degrees with 20 fraction bits
  localparam int ANG_W = 32;

  // result widths
  localparam int AZ_W = 25;
  localparam int EL_W = 23;

  localparam logic signed [ANG_W-1:0] DEG180_Q20 = 32'sd188743680;
  localparam logic [ANG_W-1:0] AZ_MAX  = 32'd23592960;
  localparam logic [ANG_W-1:0] EL_MAX  = 32'd5898240;
  localparam logic [AZ_W-1:0]  AZ_ZERO = 25'd11796480;

  // inverse cordic gain, 30 fraction bits
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
  // split point of the gain multiply into two partial products
  localparam int GAIN_SPLIT = 24;

  // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q20(input int step);
    logic signed [ANG_W-1:0] t;
    begin
      case (step)
        0:       t = 32'sd47185920;
        1:       t = 32'sd27855475;
        2:       t = 32'sd14718068;
        3:       t = 32'sd7471121;
        4:       t = 32'sd3750058;
        5:       t = 32'sd1876857;
        6:       t = 32'sd938658;
        7:       t = 32'sd469357;
        8:       t = 32'sd234682;
        9:       t = 32'sd117342;
        10:      t = 32'sd58671;
        11:      t = 32'sd29335;
        12:      t = 32'sd14668;
        13:      t = 32'sd7334;
        14:      t = 32'sd3667;
        15:      t = 32'sd1833;
        16:      t = 32'sd917;
        17:      t = 32'sd458;
        18:      t = 32'sd229;
        19:      t = 32'sd115;
        20:      t = 32'sd57;
        21:      t = 32'sd29;
        22:      t = 32'sd14;
        23:      t = 32'sd7;
        24:      t = 32'sd4;
        25:      t = 32'sd2;
        26:      t = 32'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

`default_nettype wire

[src/cae_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cae_in_if #(
  parameter int COORD_WIDTH = cae_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

interface cae_out_if;
  logic                          valid;
  logic                          ready;
  logic [cae_pkg::AZ_W-1:0]      azimuth_deg;
  logic [cae_pkg::EL_W-1:0]      elevation_deg;
  logic                          zero_vector;

  modport source (output valid, output azimuth_deg, output elevation_deg,
                  output zero_vector, input ready);
  modport sink   (input valid, input azimuth_deg, input elevation_deg,
                  input zero_vector, output ready);
endinterface

`default_nettype wire

[src/cartesian_to_azimuth_elevation.sv]
`timescale 1ns / 1ps
`default_nettype none

// cartesian to azimuth/elevation converter. takes a signed (x, y, z) request and
// returns azimuth = atan2(y, x) + 180 deg in [0, 360] and elevation =
// atan2(sqrt(x^2 + y^2), |z|) deg in [0, 90], both unsigned with 16 fraction
// bits; an all-zero vector returns 180 deg, 0 deg and zero_vector set. the
// datapath is a fixed chain of registered cordic cells: one input stage, then
// CORDIC_STEPS cells for the (x, y) pass, two stages of gain compensation, then
// CORDIC_STEPS cells for the (|z|, r_xy) pass and the output register. one
// request is taken every cycle while no result is stalled at the output. the
// output register holding a result that is not taken freezes the whole chain
// for that cycle, so in_chan.ready follows out_chan.ready whenever a result is
// pending.
module cartesian_to_azimuth_elevation #(
  parameter int COORD_WIDTH  = cae_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = cae_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cae_in_if.sink    in_chan,
  cae_out_if.source out_chan
);

  localparam int ANG_W = cae_pkg::ANG_W;
  localparam int AZ_W  = cae_pkg::AZ_W;
  localparam int EL_W  = cae_pkg::EL_W;
  // scaled coordinate plus headroom for negation and cordic growth
  localparam int XW    = COORD_WIDTH + cae_pkg::GUARD_BITS + cae_pkg::HEAD_BITS;
  localparam int N     = CORDIC_STEPS;
  // sideband through pass one: |z| and zero flag
  localparam int S1_W  = XW + 1;
  // sideband through gain: azimuth, |z| and zero flag
  localparam int SG_W  = AZ_W + XW + 1;
  // sideband through pass two: azimuth and zero flag
  localparam int S2_W  = AZ_W + 1;

  // round to 16 fraction bits, negative angles to zero
  function automatic logic [ANG_W-1:0] round_q16(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] s;
    begin
      s = (a + ANG_W'(8)) >>> 4;
      return a[ANG_W-1] ? '0 : ANG_W'(s);
    end
  endfunction

  // global advance: stall only while a result sits unaccepted
  logic en;
  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  // ---------------------------------------------------------------------------
  // input stage: scale by guard bits, fold left half plane, take |z|
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0]    xs, ys, zs;
  logic signed [XW-1:0]    x0_nxt, y0_nxt, z0_nxt;
  logic signed [ANG_W-1:0] a0_nxt;
  logic                    zero_nxt;

  assign xs = XW'(in_chan.x_coord) <<< cae_pkg::GUARD_BITS;
  assign ys = XW'(in_chan.y_coord) <<< cae_pkg::GUARD_BITS;
  assign zs = XW'(in_chan.z_coord) <<< cae_pkg::GUARD_BITS;

  always_comb begin
    zero_nxt = (in_chan.x_coord == '0) && (in_chan.y_coord == '0) &&
               (in_chan.z_coord == '0);
    z0_nxt   = zs[XW-1] ? -zs : zs;
    if (xs[XW-1]) begin
      // left half plane: rotate by 180 deg, sign follows y
      x0_nxt = -xs;
      y0_nxt = -ys;
      a0_nxt = ys[XW-1] ? -cae_pkg::DEG180_Q20 : cae_pkg::DEG180_Q20;
    end else begin
      x0_nxt = xs;
      y0_nxt = ys;
      a0_nxt = '0;
    end
  end

  logic                    v0_r;
  logic signed [XW-1:0]    x0_r, y0_r, z0_r;
  logic signed [ANG_W-1:0] a0_r;
  logic                    zero0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= x0_nxt;
      y0_r    <= y0_nxt;
      z0_r    <= z0_nxt;
      a0_r    <= a0_nxt;
      zero0_r <= zero_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // pass one: vector (x, y) -> azimuth and gain-scaled r_xy
  // ---------------------------------------------------------------------------
  logic                    p1_v [0:N];
  logic signed [XW-1:0]    p1_x [0:N];
  logic signed [XW-1:0]    p1_y [0:N];
  logic signed [ANG_W-1:0] p1_a [0:N];
  logic [S1_W-1:0]         p1_s [0:N];

  assign p1_v[0] = v0_r;
  assign p1_x[0] = x0_r;
  assign p1_y[0] = y0_r;
  assign p1_a[0] = a0_r;
  assign p1_s[0] = {z0_r, zero0_r};

  for (genvar i = 0; i < N; i++) begin : g_pass1
    cae_cell #(
      .XW     (XW),
      .STEP   (i),
      .SIDE_W (S1_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (p1_v[i]),
      .x_i    (p1_x[i]),
      .y_i    (p1_y[i]),
      .a_i    (p1_a[i]),
      .side_i (p1_s[i]),
      .v_o    (p1_v[i+1]),
      .x_o    (p1_x[i+1]),
      .y_o    (p1_y[i+1]),
      .a_o    (p1_a[i+1]),
      .side_o (p1_s[i+1])
    );
  end

  // azimuth rounded and saturated as it leaves pass one
  logic [ANG_W-1:0] az_rnd;
  logic [AZ_W-1:0]  az_val;

  assign az_rnd = round_q16(p1_a[N] + cae_pkg::DEG180_Q20);
  assign az_val = (az_rnd > cae_pkg::AZ_MAX) ? AZ_W'(cae_pkg::AZ_MAX) : az_rnd[AZ_W-1:0];

  // ---------------------------------------------------------------------------
  // gain compensation of r_xy
  // ---------------------------------------------------------------------------
  logic                 g_v;
  logic signed [XW-1:0] g_r;
  logic [SG_W-1:0]      g_s;

  cae_gain #(
    .XW     (XW),
    .SIDE_W (SG_W)
  ) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (p1_v[N]),
    .x_i    (p1_x[N]),
    .side_i ({az_val, p1_s[N]}),
    .v_o    (g_v),
    .r_o    (g_r),
    .side_o (g_s)
  );

  // ---------------------------------------------------------------------------
  // pass two: vector (|z|, r_xy) -> elevation
  // ---------------------------------------------------------------------------
  logic                    p2_v [0:N];
  logic signed [XW-1:0]    p2_x [0:N];
  logic signed [XW-1:0]    p2_y [0:N];
  logic signed [ANG_W-1:0] p2_a [0:N];
  logic [S2_W-1:0]         p2_s [0:N];

  assign p2_v[0] = g_v;
  assign p2_x[0] = g_s[XW:1];
  assign p2_y[0] = g_r;
  assign p2_a[0] = '0;
  assign p2_s[0] = {g_s[SG_W-1:XW+1], g_s[0]};

  for (genvar i = 0; i < N; i++) begin : g_pass2
    cae_cell #(
      .XW     (XW),
      .STEP   (i),
      .SIDE_W (S2_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (p2_v[i]),
      .x_i    (p2_x[i]),
      .y_i    (p2_y[i]),
      .a_i    (p2_a[i]),
      .side_i (p2_s[i]),
      .v_o    (p2_v[i+1]),
      .x_o    (p2_x[i+1]),
      .y_o    (p2_y[i+1]),
      .a_o    (p2_a[i+1]),
      .side_o (p2_s[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // output register: elevation rounding, zero vector defaults
  // ---------------------------------------------------------------------------
  logic [ANG_W-1:0] el_rnd;
  logic [EL_W-1:0]  el_val;
  logic             zero_fin;

  assign zero_fin = p2_s[N][0];
  assign el_rnd   = round_q16(p2_a[N]);
  assign el_val   = (el_rnd > cae_pkg::EL_MAX) ? EL_W'(cae_pkg::EL_MAX) : el_rnd[EL_W-1:0];

  logic            out_valid_r;
  logic [AZ_W-1:0] az_r;
  logic [EL_W-1:0] el_r;
  logic            zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p2_v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_r   <= zero_fin ? cae_pkg::AZ_ZERO : p2_s[N][S2_W-1:1];
      el_r   <= zero_fin ? '0 : el_val;
      zero_r <= zero_fin;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.azimuth_deg   = az_r;
  assign out_chan.elevation_deg = el_r;
  assign out_chan.zero_vector   = zero_r;

  // unused final residues of the vectoring passes
  logic unused_res;
  assign unused_res = ^{p1_y[N], p2_x[N], p2_y[N]};

endmodule

`default_nettype wire

[src/cae_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// one cordic vectoring micro-rotation, registered
module cae_cell #(
  parameter int XW     = 43,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            v_i,
  input  wire logic signed [XW-1:0]            x_i,
  input  wire logic signed [XW-1:0]            y_i,
  input  wire logic signed [cae_pkg::ANG_W-1:0] a_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output logic                                 v_o,
  output logic signed [XW-1:0]                 x_o,
  output logic signed [XW-1:0]                 y_o,
  output logic signed [cae_pkg::ANG_W-1:0]     a_o,
  output logic [SIDE_W-1:0]                    side_o
);

  localparam logic signed [cae_pkg::ANG_W-1:0] ATAN_Q20 = cae_pkg::atan_q20(STEP);

  logic                                v_r;
  logic signed [XW-1:0]                x_r, x_nxt;
  logic signed [XW-1:0]                y_r, y_nxt;
  logic signed [cae_pkg::ANG_W-1:0]    a_r, a_nxt;
  logic [SIDE_W-1:0]                   side_r;
  logic signed [XW-1:0]                dx, dy;

  // floor shifts
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      a_nxt = a_i + ATAN_Q20;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      a_nxt = a_i - ATAN_Q20;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign a_o    = a_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[src/cae_gain.sv]
`timescale 1ns / 1ps
`default_nettype none

// inverse cordic gain: (x * INV_GAIN_Q30) >> 30 for positive x, else zero, two partial products then sum
module cae_gain #(
  parameter int XW     = 43,
  parameter int SIDE_W = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      v_o,
  output logic signed [XW-1:0]      r_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int SPLIT = cae_pkg::GAIN_SPLIT;
  localparam int HI_W  = XW - SPLIT;
  localparam int HP_W  = HI_W + cae_pkg::GAIN_W;
  localparam int LP_W  = SPLIT + cae_pkg::GAIN_W;
  localparam int SUM_W = XW + cae_pkg::GAIN_W + 1;

  logic              va_r, vb_r;
  logic              pos_r;
  logic [HP_W-1:0]   hi_r;
  logic [LP_W-1:0]   lo_r;
  logic [SIDE_W-1:0] sidea_r, sideb_r;
  logic signed [XW-1:0] r_r, r_nxt;
  logic [SUM_W-1:0]  sum;

  // stage b: recombine partial products, drop 30 fraction bits
  assign sum = ({{(SUM_W-HP_W){1'b0}}, hi_r} << SPLIT) + {{(SUM_W-LP_W){1'b0}}, lo_r};
  assign r_nxt = pos_r ? sum[XW+cae_pkg::GAIN_W-1:cae_pkg::GAIN_W] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r   <= !x_i[XW-1] && (x_i != '0);
      hi_r    <= HP_W'(x_i[XW-1:SPLIT]) * HP_W'(cae_pkg::INV_GAIN_Q30);
      lo_r    <= LP_W'(x_i[SPLIT-1:0]) * LP_W'(cae_pkg::INV_GAIN_Q30);
      sidea_r <= side_i;
      r_r     <= r_nxt;
      sideb_r <= sidea_r;
    end
  end

  assign v_o    = vb_r;
  assign r_o    = r_r;
  assign side_o = sideb_r;

endmodule

`default_nettype wire

[src/cae_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module cae_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [cae_pkg::AZ_W-1:0] azimuth_deg,
  input wire logic [cae_pkg::EL_W-1:0] elevation_deg,
  input wire logic                     zero_vector
);

  // a result that is not taken keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(azimuth_deg) &&
    $stable(elevation_deg) && $stable(zero_vector))
    else $error("result changed while stalled");

  // input is refused only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stalled result");

  // zero vector carries fixed angles
  a_zero_def: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_vector |->
    azimuth_deg == cae_pkg::AZ_ZERO && elevation_deg == '0)
    else $error("zero vector angles wrong");

  // angles stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {7'd0, azimuth_deg} <= cae_pkg::AZ_MAX &&
    {9'd0, elevation_deg} <= cae_pkg::EL_MAX)
    else $error("angle out of range");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  logic unused_in;
  assign unused_in = in_valid;

endmodule

bind cartesian_to_azimuth_elevation cae_checker u_cae_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .azimuth_deg   (out_chan.azimuth_deg),
  .elevation_deg (out_chan.elevation_deg),
  .zero_vector   (out_chan.zero_vector)
);

`default_nettype wire

[tb/sv/cae_angle_checker.sv]
`timescale 1ns / 1ps

module cae_angle_checker #(
  parameter int COORD_WIDTH  = cae_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = cae_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cae_in_if         in_chan,
  cae_out_if        out_chan,
  output int        fail_count,
  output int        pending_count
);

  localparam int AZW = cae_pkg::AZ_W;
  localparam int ELW = cae_pkg::EL_W;

  typedef struct packed {
    logic [AZW-1:0] azimuth;
    logic [ELW-1:0] elevation;
    logic           zero;
  } angles_t;

  localparam longint GUARD_SCALE   = 65536;
  localparam longint HALF_TURN_Q20 = 188743680;
  localparam longint AZ_TOP        = 23592960;
  localparam longint EL_TOP        = 5898240;
  localparam longint AZ_FLAT       = 11796480;
  localparam logic [95:0] INV_GAIN_Q30 = 96'd652032874;

  // atan(2^-i) in degrees, q20
  localparam longint ATAN_DEG_Q20 [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  angles_t angle_due[$];

  // drive (px, py) onto the positive x axis, accumulating the angle
  function automatic longint swing_to_axis(inout longint px, inout longint py,
                                           input longint ang);
    longint dx, dy;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px  = px + dx;
        py  = py - dy;
        ang = ang + ATAN_DEG_Q20[i];
      end else begin
        px  = px - dx;
        py  = py + dy;
        ang = ang - ATAN_DEG_Q20[i];
      end
    end
    return ang;
  endfunction

  function automatic longint undo_gain(input longint v);
    logic [95:0] prod;
    if (v <= 0) return 0;
    prod = 96'(v) * INV_GAIN_Q30;
    return longint'(prod >> 30);
  endfunction

  // q20 angle to q16, floor at zero, saturate at top
  function automatic longint to_q16(input longint ang, input longint top);
    longint r;
    if (ang < 0) ang = 0;
    r = (ang + 8) >>> 4;
    if (r > top) r = top;
    return r;
  endfunction

  function automatic angles_t solve_angles(input logic signed [COORD_WIDTH-1:0] xc,
                                           input logic signed [COORD_WIDTH-1:0] yc,
                                           input logic signed [COORD_WIDTH-1:0] zc);
    longint  x, y, z, ang, rxy;
    angles_t r;
    x = longint'(xc);
    y = longint'(yc);
    z = longint'(zc);
    if (x == 0 && y == 0 && z == 0) begin
      r.azimuth   = AZW'(AZ_FLAT);
      r.elevation = '0;
      r.zero      = 1'b1;
      return r;
    end
    x = x * GUARD_SCALE;
    y = y * GUARD_SCALE;
    z = z * GUARD_SCALE;
    if (z < 0) z = -z;
    ang = 0;
    // left half plane: reflect through the origin, start at +-180
    if (x < 0) begin
      ang = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
      x   = -x;
      y   = -y;
    end
    ang       = swing_to_axis(x, y, ang);
    r.azimuth = AZW'(to_q16(ang + HALF_TURN_Q20, AZ_TOP));
    rxy       = undo_gain(x);
    ang       = swing_to_axis(z, rxy, 0);
    r.elevation = ELW'(to_q16(ang, EL_TOP));
    r.zero      = 1'b0;
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    angles_t want, got;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.azimuth_deg, out_chan.elevation_deg, out_chan.zero_vector};
        if (angle_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result az=%0d el=%0d zero=%0b",
                     got.azimuth, got.elevation, got.zero);
        end else begin
          want = angle_due.pop_front();
          if (got.azimuth !== want.azimuth || got.elevation !== want.elevation ||
              got.zero !== want.zero) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: want az=%0d el=%0d zero=%0b, got az=%0d el=%0d zero=%0b",
                       want.azimuth, want.elevation, want.zero,
                       got.azimuth, got.elevation, got.zero);
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        angle_due.push_back(solve_angles(in_chan.x_coord, in_chan.y_coord,
                                         in_chan.z_coord));
      pending_count = angle_due.size();
    end
  end

endmodule

[tb/sv/tb_cartesian_to_azimuth_elevation.sv]
`timescale 1ns / 1ps

module tb_cartesian_to_azimuth_elevation;

  localparam int CW           = cae_pkg::COORD_WIDTH_DEF;
  localparam int STEPS        = cae_pkg::CORDIC_STEPS_DEF;
  // pipeline depth as given for the block
  localparam int LATENCY      = 2 * STEPS + 4;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 500;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic clk;
  logic rst_n;
  // when set, neither side idles
  logic calm;
  int   stall_cycles;
  int   fail_count;
  int   pending_count;

  cae_in_if #(.COORD_WIDTH(CW)) in_if ();
  cae_out_if                    out_if ();

  cartesian_to_azimuth_elevation #(
    .COORD_WIDTH (CW),
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // predicts every accepted request and checks each result against it
  cae_angle_checker #(
    .COORD_WIDTH (CW),
    .CORDIC_STEPS(STEPS)
  ) angle_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_if),
    .out_chan     (out_if),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side backpressure, changed on the falling edge only
  always @(negedge clk) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // hang detection: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one request: random idle gaps first, then hold valid until taken.
  // each falling edge the task waits on sees exactly one assignment to valid
  task automatic send_vector(input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.x_coord <= x;
    in_if.y_coord <= y;
    in_if.z_coord <= z;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // signed value spread over w magnitude bits
  function automatic logic signed [CW-1:0] scaled_coord(input int w);
    return CW'(int'($urandom()) >>> (31 - w));
  endfunction

  function automatic logic signed [CW-1:0] edge_coord();
    case ($urandom_range(4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return CW'(1);
      default: return '1;
    endcase
  endfunction

  task automatic random_vector(output logic signed [CW-1:0] x,
                               output logic signed [CW-1:0] y,
                               output logic signed [CW-1:0] z);
    int kind;
    int w;
    logic [2:0] drop;
    kind = $urandom_range(9);
    x = CW'($urandom());
    y = CW'($urandom());
    z = CW'($urandom());
    case (kind)
      4, 5: begin
        // magnitudes of a random bit width, down to small ones where truncation in the passes matters most
        w = $urandom_range(1, CW - 1);
        x = scaled_coord(w);
        y = scaled_coord(w);
        z = scaled_coord(w);
      end
      6: begin
        // some axes zeroed, occasionally all of them
        drop = 3'($urandom_range(1, 7));
        if (drop[0]) x = '0;
        if (drop[1]) y = '0;
        if (drop[2]) z = '0;
      end
      7: begin
        x = edge_coord();
        y = edge_coord();
        z = edge_coord();
      end
      8: begin
        // near the negative x axis, azimuth wraps between 0 and 360
        x = (x[CW-1]) ? x : -x;
        if (x == 0) x = C_MIN;
        y = CW'(int'($urandom_range(2)) - 1);
      end
      9: begin
        // mixed scales between the horizontal and vertical parts
        w = $urandom_range(1, 8);
        x = scaled_coord(w);
        y = scaled_coord(w);
        if ($urandom_range(1)) begin
          z = scaled_coord(w);
          x = CW'($urandom());
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    logic signed [CW-1:0] rx, ry, rz;
    rst_n         = 1'b0;
    calm          = 1'b0;
    in_if.valid   = 1'b0;
    in_if.x_coord = '0;
    in_if.y_coord = '0;
    in_if.z_coord = '0;
    out_if.ready  = 1'b0;
    stall_cycles  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero vector, axes, half plane cases, extremes
    send_vector('0, '0, '0);
    send_vector(C_MAX, C_MAX, C_MAX);
    send_vector(C_MIN, C_MIN, C_MIN);
    send_vector(C_MIN, '0, '0);
    send_vector(-CW'(1000), '0, CW'(5));
    send_vector(-CW'(1000), CW'(1), CW'(5));
    send_vector(-CW'(1000), -CW'(1), CW'(5));
    send_vector(C_MAX, '0, '0);
    send_vector('0, C_MAX, '0);
    send_vector('0, C_MIN, '0);
    send_vector('0, '0, C_MAX);
    send_vector('0, '0, C_MIN);
    send_vector(CW'(1), '0, '0);
    send_vector(-CW'(1), '0, '0);
    send_vector('0, '0, CW'(1));
    send_vector('0, '0, -CW'(1));
    send_vector(CW'(1), CW'(1), CW'(1));
    send_vector(-CW'(1), -CW'(1), -CW'(1));
    send_vector(C_MAX, C_MIN, C_MAX);
    send_vector(C_MIN, C_MAX, C_MIN);
    send_vector(C_MIN, C_MIN, '0);
    send_vector(CW'(3), -CW'(4), CW'(12));

    // random part, with a stretch in the middle where nobody idles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 150 && n < 270);
      random_vector(rx, ry, rz);
      send_vector(rx, ry, rz);
    end
    calm = 1'b0;
    @(negedge clk);
    in_if.valid <= 1'b0;

    // drain, then a latency's worth of quiet to catch stray results
    wait (pending_count == 0);
    repeat (LATENCY + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/cae_pkg.sv
src/cae_if.sv
src/cae_cell.sv
src/cae_gain.sv
src/cartesian_to_azimuth_elevation.sv
src/cae_checker.sv
tb/sv/cae_angle_checker.sv
tb/sv/tb_cartesian_to_azimuth_elevation.sv
